@@ rtl/pal_pkg.sv @@
// package for the positional array list: payload types, codes and defaults
package pal_pkg;

    localparam int DEFAULT_CAPACITY = 128;
    localparam int POS_W = 7;
    localparam int VAL_W = 32;
    localparam int LEN_W = 8;

    typedef enum logic [1:0] {
        OP_APPEND   = 2'd0,
        OP_INSERT   = 2'd1,
        OP_REMOVE   = 2'd2,
        OP_RETRIEVE = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    typedef struct packed {
        opcode_t                   opcode;
        logic [POS_W-1:0]          position;
        logic signed [VAL_W-1:0]   value;
    } in_t;

    typedef struct packed {
        status_t                   status;
        logic signed [VAL_W-1:0]   read_value;
        logic [LEN_W-1:0]          list_length;
        logic                      is_empty;
    } out_t;

    // broadcast to every cell of the chain
    typedef struct packed {
        logic                      ins;
        logic                      rem;
        logic signed [VAL_W-1:0]   value;
    } cell_ctrl_t;

endpackage

@@ rtl/positional_array_list.sv @@
// top level of the positional array list: control, count and a chain of entry cells
// an accepted request's result is registered and shows in the cycle after its acceptance
// one request per cycle while results are taken; each cell compares its index and shifts
// in that cycle; the output register frees as it is taken, so a new request enters while
// a result is taken. reset: aresetn low clears the length and the result valid; entry cells
// are not cleared and only entries below the length are ever read
module positional_array_list #(
    parameter int CAPACITY = pal_pkg::DEFAULT_CAPACITY
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  pal_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output pal_pkg::out_t m_data
);
    import pal_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > POS_W) ? CW : POS_W;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    logic [CW-1:0] count_reg, count_next;
    logic          m_valid_reg;
    out_t          out_reg, out_next;

    logic          accept;
    logic [PW-1:0] pos_ext, cnt_ext, pos_sel;
    logic          full;
    status_t       status;
    logic          do_ins, do_rem, do_rd;
    cell_ctrl_t    ctrl;

    logic signed [VAL_W-1:0] cell_data [CAPACITY];
    logic signed [VAL_W-1:0] cell_rd   [CAPACITY];
    logic signed [VAL_W-1:0] rd_or;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    assign pos_ext = PW'(s_data.position);
    assign cnt_ext = PW'(count_reg);
    assign full    = (count_reg == CAP_C);

    always_comb begin
        status = ST_OK;
        do_ins = 1'b0;
        do_rem = 1'b0;
        do_rd  = 1'b0;
        unique case (s_data.opcode)
            OP_APPEND: begin
                if (full) status = ST_FULL;
                else      do_ins = 1'b1;
            end
            OP_INSERT: begin
                if (full)                   status = ST_FULL;
                else if (pos_ext > cnt_ext) status = ST_RANGE;
                else                        do_ins = 1'b1;
            end
            OP_REMOVE: begin
                if (pos_ext >= cnt_ext) status = ST_RANGE;
                else                    do_rem = 1'b1;
            end
            OP_RETRIEVE: begin
                if (pos_ext >= cnt_ext) status = ST_RANGE;
                else                    do_rd = 1'b1;
            end
            default: status = ST_RANGE;
        endcase
    end

    // append is an insert at the current length
    assign pos_sel    = (s_data.opcode == OP_APPEND) ? cnt_ext : pos_ext;
    assign ctrl.ins   = accept && do_ins;
    assign ctrl.rem   = accept && do_rem;
    assign ctrl.value = s_data.value;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic signed [VAL_W-1:0] left_d, right_d;
        if (i == 0) begin : g_first
            assign left_d = '0;
        end else begin : g_left
            assign left_d = cell_data[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign right_d = '0;
        end else begin : g_right
            assign right_d = cell_data[i+1];
        end
        pal_cell #(
            .PW  (PW),
            .IDX (i)
        ) u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl),
            .pos        (pos_sel),
            .left_data  (left_d),
            .right_data (right_d),
            .data       (cell_data[i]),
            .rd         (cell_rd[i])
        );
    end

    always_comb begin
        rd_or = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            rd_or = rd_or | cell_rd[i];
        end
    end

    always_comb begin
        count_next = count_reg;
        if (ctrl.ins)      count_next = count_reg + CW'(1);
        else if (ctrl.rem) count_next = count_reg - CW'(1);
    end

    always_comb begin
        out_next.status      = status;
        out_next.read_value  = do_rd ? rd_or : '0;
        out_next.list_length = LEN_W'(count_next);
        out_next.is_empty    = (count_next == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (accept)       m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) out_reg <= out_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

@@ rtl/pal_cell.sv @@
// one list entry: shifts up on insert, down on remove, drives its value on a matching read
module pal_cell #(
    parameter int PW  = 7,
    parameter int IDX = 0
) (
    input  logic                         aclk,
    input  pal_pkg::cell_ctrl_t          ctrl,
    input  logic [PW-1:0]                pos,
    input  logic signed [pal_pkg::VAL_W-1:0] left_data,
    input  logic signed [pal_pkg::VAL_W-1:0] right_data,
    output logic signed [pal_pkg::VAL_W-1:0] data,
    output logic signed [pal_pkg::VAL_W-1:0] rd
);
    import pal_pkg::*;

    localparam logic [PW-1:0] MY_IDX = PW'(IDX);

    logic signed [VAL_W-1:0] data_reg;
    logic signed [VAL_W-1:0] data_next;

    always_comb begin
        data_next = data_reg;
        if (ctrl.ins) begin
            if (MY_IDX > pos) begin
                data_next = left_data;
            end else if (MY_IDX == pos) begin
                data_next = ctrl.value;
            end
        end else if (ctrl.rem) begin
            if (MY_IDX >= pos) begin
                data_next = right_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data = data_reg;
    // and-or read bus: only the addressed cell contributes
    assign rd   = (MY_IDX == pos) ? data_reg : '0;

endmodule

@@ rtl/pal_checker.sv @@
// port-level checks for the positional array list, bound to the top level
module pal_checker (
    input logic          aclk,
    input logic          aresetn,
    input logic          s_valid,
    input logic          s_ready,
    input pal_pkg::in_t  s_data,
    input logic          m_valid,
    input logic          m_ready,
    input pal_pkg::out_t m_data
);
    import pal_pkg::*;

    // a waiting result stays until taken
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");

    // an empty output register always takes a request
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("not ready with empty output");

    // a rejected full write leaves a non-empty list
    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == ST_FULL |-> !m_data.is_empty)
        else $error("full status on empty list");

    // a nonzero read only comes with ok status and a stored element
    a_read: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.read_value != '0 |->
            m_data.status == ST_OK && !m_data.is_empty)
        else $error("read value on rejected or empty request");

    // every result follows a request accepted in the previous cycle or is a held one
    a_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready))
        else $error("result without a request");

endmodule

bind positional_array_list pal_checker u_pal_checker (.*);

@@ dv/testbench.sv @@
// self-checking testbench for positional_array_list: shadow list, random requests, stalls
module testbench;
    import pal_pkg::*;

    localparam int CAPACITY = DEFAULT_CAPACITY;
    localparam int N_RANDOM = 1100;
    localparam int PHASE_LEN = 200;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_AT = 300;
    localparam int HOLD_CYCLES = 400;

    // shadow copy of the list, predicts one response per request
    class list_mirror;
        logic signed [VAL_W-1:0] shadow [CAPACITY];
        int unsigned length;
        out_t pending_responses [$];
        int errors;
        int responses_seen;
        int op_count [4];
        int full_rejects;
        int range_rejects;
        int unsigned peak_length;

        function new();
            length = 0;
            errors = 0;
            responses_seen = 0;
            full_rejects = 0;
            range_rejects = 0;
            peak_length = 0;
            foreach (op_count[i]) op_count[i] = 0;
        endfunction

        function void apply_request(in_t req);
            out_t want;
            int k;
            want.status = ST_OK;
            want.read_value = '0;
            op_count[req.opcode]++;
            case (req.opcode)
                OP_APPEND: begin
                    if (length >= CAPACITY) begin
                        want.status = ST_FULL;
                    end else begin
                        shadow[length] = req.value;
                        length++;
                    end
                end
                OP_INSERT: begin
                    // full wins over a bad position
                    if (length >= CAPACITY) begin
                        want.status = ST_FULL;
                    end else if (req.position > length) begin
                        want.status = ST_RANGE;
                    end else begin
                        for (k = length; k > req.position; k--) shadow[k] = shadow[k-1];
                        shadow[req.position] = req.value;
                        length++;
                    end
                end
                OP_REMOVE: begin
                    if (req.position >= length) begin
                        want.status = ST_RANGE;
                    end else begin
                        for (k = req.position; k + 1 < length; k++) shadow[k] = shadow[k+1];
                        length--;
                    end
                end
                default: begin
                    if (req.position >= length) want.status = ST_RANGE;
                    else want.read_value = shadow[req.position];
                end
            endcase
            if (want.status == ST_FULL) full_rejects++;
            if (want.status == ST_RANGE) range_rejects++;
            if (length > peak_length) peak_length = length;
            want.list_length = length[LEN_W-1:0];
            want.is_empty = (length == 0);
            pending_responses.push_back(want);
        endfunction

        function void compare_response(out_t got);
            out_t want;
            responses_seen++;
            if (pending_responses.size() == 0) begin
                $display("%0t: response with no request waiting: got %h", $time, got);
                errors++;
                return;
            end
            want = pending_responses.pop_front();
            if (got.status !== want.status) begin
                $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
                errors++;
            end
            if (got.read_value !== want.read_value) begin
                $display("%0t: read_value expected %0d actual %0d",
                         $time, want.read_value, got.read_value);
                errors++;
            end
            if (got.list_length !== want.list_length) begin
                $display("%0t: list_length expected %0d actual %0d",
                         $time, want.list_length, got.list_length);
                errors++;
            end
            if (got.is_empty !== want.is_empty) begin
                $display("%0t: is_empty expected %0d actual %0d",
                         $time, want.is_empty, got.is_empty);
                errors++;
            end
        endfunction

        function int pending();
            return pending_responses.size();
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;

    list_mirror mirror = new();
    int cycle_count = 0;
    int sent = 0;

    positional_array_list #(
        .CAPACITY(CAPACITY)
    ) i_dut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("positional_array_list: mismatch");
            $finish;
        end
    end

    // some stretches run with no idle cycles at all
    function automatic int draw_gap(int idx);
        if ((idx / 64) % 3 == 0) return 0;
        return $urandom_range(0, 8);
    endfunction

    task automatic send_request(in_t req);
        int gap;
        gap = draw_gap(sent);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= req;
        do @(posedge aclk); while (!s_ready);
        mirror.apply_request(req);
        sent++;
    endtask

    task automatic send_op(opcode_t op, int pos, logic [VAL_W-1:0] val);
        in_t req;
        req.opcode = op;
        req.position = pos[POS_W-1:0];
        req.value = val;
        send_request(req);
    endtask

    // growing phases mostly add, shrinking phases mostly remove
    function automatic in_t make_random_request(bit growing, int unsigned len);
        in_t req;
        int r;
        r = $urandom_range(0, 99);
        if (growing) begin
            if (r < 45) req.opcode = OP_APPEND;
            else if (r < 85) req.opcode = OP_INSERT;
            else if (r < 93) req.opcode = OP_RETRIEVE;
            else req.opcode = OP_REMOVE;
        end else begin
            if (r < 8) req.opcode = OP_APPEND;
            else if (r < 15) req.opcode = OP_INSERT;
            else if (r < 30) req.opcode = OP_RETRIEVE;
            else req.opcode = OP_REMOVE;
        end
        req.value = $urandom;
        if (req.opcode == OP_APPEND || $urandom_range(0, 99) < 15) begin
            req.position = POS_W'($urandom_range(0, 127));
        end else if (req.opcode == OP_INSERT) begin
            req.position = POS_W'($urandom_range(0, len));
        end else begin
            req.position = (len > 0) ? POS_W'($urandom_range(0, len - 1)) : '0;
        end
        return req;
    endfunction

    // response side with random back-pressure and one long hold-off
    initial begin
        int taken;
        int hold;
        taken = 0;
        while (!aresetn) @(posedge aclk);
        forever begin
            hold = (taken == HOLD_AT) ? HOLD_CYCLES
                 : ((taken / 50) % 4 == 0) ? 0 : $urandom_range(0, 8);
            if (hold > 0) begin
                m_ready <= 1'b0;
                repeat (hold) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            mirror.compare_response(m_data);
            taken++;
        end
    end

    initial begin
        int drain;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty list rejects retrieve, remove and an insert past the length
        send_op(OP_RETRIEVE, 0, 32'h1234_5678);
        send_op(OP_REMOVE, 0, 32'h0);
        send_op(OP_INSERT, 1, 32'h1);
        send_op(OP_INSERT, 0, 32'h8000_0000);
        send_op(OP_APPEND, 127, 32'h7FFF_FFFF);
        send_op(OP_APPEND, 0, 32'h0);
        send_op(OP_APPEND, 64, 32'hFFFF_FFFF);
        // insert at the length acts as append
        send_op(OP_INSERT, 4, 32'h5);
        send_op(OP_INSERT, 2, 32'h5555_5555);
        send_op(OP_RETRIEVE, 5, 32'hFFFF_FFFF);
        send_op(OP_RETRIEVE, 0, 32'h0);
        send_op(OP_RETRIEVE, 6, 32'h0);
        send_op(OP_RETRIEVE, 127, 32'h0);
        send_op(OP_REMOVE, 5, 32'h0);
        send_op(OP_REMOVE, 0, 32'h0);
        send_op(OP_INSERT, 127, 32'h7);
        send_op(OP_REMOVE, 127, 32'h0);
        send_op(OP_RETRIEVE, 2, 32'h0);
        send_op(OP_APPEND, 127, 32'hAAAA_AAAA);
        send_op(OP_INSERT, 0, 32'h0000_FFFF);
        send_op(OP_RETRIEVE, 0, 32'h0);

        for (int i = 0; i < N_RANDOM; i++) begin
            send_request(make_random_request(((i / PHASE_LEN) % 2) == 0, mirror.length));
        end
        s_valid <= 1'b0;

        while (mirror.pending() > 0) @(posedge aclk);
        drain = 4;
        repeat (drain) @(posedge aclk);

        $display("ran %0d requests (append %0d, insert %0d, remove %0d, retrieve %0d)",
                 sent, mirror.op_count[OP_APPEND], mirror.op_count[OP_INSERT],
                 mirror.op_count[OP_REMOVE], mirror.op_count[OP_RETRIEVE]);
        $display("full rejects %0d, range rejects %0d, peak length %0d, %0d responses checked",
                 mirror.full_rejects, mirror.range_rejects, mirror.peak_length,
                 mirror.responses_seen);
        if (mirror.errors == 0 && mirror.pending() == 0) begin
            $display("positional_array_list: match");
        end else begin
            $display("positional_array_list: mismatch");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/pal_pkg.sv
rtl/pal_cell.sv
rtl/positional_array_list.sv
rtl/pal_checker.sv
dv/testbench.sv
